>>> hdl/assert_macros.svh
// Assertion macros shared by the point table search RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTNS_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("%m: property failed");

// Condition must never be seen outside reset.
`define PTNS_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

>>> hdl/ptns_pkg.sv
// Package for the point table nearest search block: codes, defaults, helpers.
// No dependencies; used by the interfaces and every module.
package ptns_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int DIST_W         = 17;
    localparam int CNT_W          = 7;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        FN_ADD     = 2'd0,
        FN_REMOVE  = 2'd1,
        FN_MEMBER  = 2'd2,
        FN_NEAREST = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control of the queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        func_t func;
    } q_ctl_t;

    // Saturate a count to the output field width.
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [31:0] v);
        logic [CNT_W-1:0] r;
        r = (v > 32'd127) ? 7'd127 : v[CNT_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/ptns_if.sv
// Channel interfaces for the point table search: request and response.
// Depends on ptns_pkg.
interface ptns_req_if
    import ptns_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;

    modport source (output valid, func, pos_x, pos_y, input ready);
    modport sink   (input valid, func, pos_x, pos_y, output ready);
endinterface

interface ptns_rsp_if
    import ptns_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic                         found;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic [DIST_W-1:0]            near_dist;
    logic [CNT_W-1:0]             removed_count;
    logic [CNT_W-1:0]             entry_count;

    modport source (output valid, status, found, near_x, near_y, near_dist,
                    removed_count, entry_count, input ready);
    modport sink   (input valid, status, found, near_x, near_y, near_dist,
                    removed_count, entry_count, output ready);
endinterface

>>> hdl/point_table_nearest_search_top.sv
// Top level of the point table nearest search block.
// Depends on ptns_pkg, ptns_if, ptns_front and ptns_back.
//
// Use: requests arrive as beats on req (func, pos_x, pos_y); one response
// beat per request leaves on rsp, in request order. func selects add,
// remove, membership query or nearest query on a table of up to CAPACITY
// signed points kept in a single-port-write, single-port-read memory.
// A two-beat queue in the front end takes requests while the back end is
// busy; the back end walks the table one entry at a time.
// Add and empty nearest go straight to the result; remove and membership
// scan the N stored points once; nearest, with COORD_BITS = B, is set by
// the bit-serial square root (B + 1 steps per entry) behind one squaring
// stage. One request is worked on at a time.
// The result register frees the back end as soon as rsp takes the beat; a
// stalled rsp holds the beat and the back end waits in its final state,
// while the queue keeps taking requests until it holds two.
// Reset empties the table and the queue; no clearing pass is needed,
// since only entries below the stored count are ever read.
`include "assert_macros.svh"

module point_table_nearest_search_top
    import ptns_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    ptns_req_if.sink  req,
    ptns_rsp_if.source rsp
);
    q_ctl_t                head;
    logic [COORD_BITS-1:0] head_x, head_y;
    logic                  pop;

    // Front end: accept and queue request beats.
    ptns_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .head   (head),
        .head_x (head_x),
        .head_y (head_y),
        .pop    (pop)
    );

    // Back end: carry out one request against the table.
    ptns_back #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .head_x (head_x),
        .head_y (head_y),
        .pop    (pop),
        .rsp    (rsp)
    );

    // A pop only ever takes a queued beat.
    `PTNS_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !head.valid)
endmodule

>>> hdl/ptns_front.sv
// Front end: accepts request beats, decodes the function and queues them.
// Depends on ptns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptns_front
    import ptns_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    ptns_req_if.sink              req,
    output q_ctl_t                head,
    output logic [COORD_BITS-1:0] head_x,
    output logic [COORD_BITS-1:0] head_y,
    input  logic                  pop
);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);

    func_t                 func_reg [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] x_reg    [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] y_reg    [QUEUE_DEPTH];
    logic [PW-1:0]         wp_reg, wp_next, rp_reg, rp_next;
    logic [LW-1:0]         level_reg, level_next;
    logic                  push, do_pop;

    assign req.ready = (level_reg != LW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (level_reg != '0);

    always_comb
    begin
        wp_next    = push   ? PW'(wp_reg + 1'b1) : wp_reg;
        rp_next    = do_pop ? PW'(rp_reg + 1'b1) : rp_reg;
        level_next = LW'(level_reg + LW'(push) - LW'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            func_reg[wp_reg] <= func_t'(req.func);
            x_reg[wp_reg]    <= req.pos_x;
            y_reg[wp_reg]    <= req.pos_y;
        end
    end

    assign head.valid = (level_reg != '0);
    assign head.func  = func_reg[rp_reg];
    assign head_x     = x_reg[rp_reg];
    assign head_y     = y_reg[rp_reg];

    `PTNS_ASSERT(a_level_bound, clk, rst_n, level_reg <= LW'(QUEUE_DEPTH))
    `PTNS_ASSERT(a_level_track, clk, rst_n,
        (push && !do_pop) |=> (level_reg == $past(level_reg) + 1'b1))
endmodule

>>> hdl/ptns_back.sv
// Back end: point memory, scan sequencer, serial square root, result register.
// Depends on ptns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptns_back
    import ptns_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_ctl_t                head,
    input  logic [COORD_BITS-1:0] head_x,
    input  logic [COORD_BITS-1:0] head_y,
    output logic                  pop,
    ptns_rsp_if.source            rsp
);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int CB  = COORD_BITS;
    localparam int RW  = CB + 1;
    localparam int SW  = 2 * RW;
    localparam int SCW = $clog2(RW + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_ROOT = 8'b0010_0000,
        S_BEST = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    logic [2*CB-1:0] mem [CAPACITY];
    logic [2*CB-1:0] rd_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [2*CB-1:0] mem_wd;

    state_t          state_reg, state_next;
    func_t           op_reg, op_next;
    status_t         st_reg, st_next;
    logic [CB-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [CW-1:0]   count_reg, count_next, idx_reg, idx_next;
    logic [CW-1:0]   wr_reg, wr_next, rem_cnt_reg, rem_cnt_next;
    logic            found_reg, found_next, have_reg, have_next;
    logic [RW-1:0]   best_d_reg, best_d_next;
    logic [CB-1:0]   best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [RW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [SW-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SW-1:0]   rad_reg, rad_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [SCW-1:0]  step_reg, step_next;

    logic            out_valid_reg, out_valid_next;
    status_t         o_st_reg, o_st_next;
    logic            o_found_reg, o_found_next;
    logic [CB-1:0]   o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic [DIST_W-1:0] o_d_reg, o_d_next;
    logic [CNT_W-1:0]  o_rm_reg, o_rm_next, o_cnt_reg, o_cnt_next;

    logic [CB-1:0]   sx, sy;
    logic [RW:0]     ddx, ddy;
    logic [RW+2:0]   t, trial;
    logic            ge, out_free, hit;

    assign sx       = rd_reg[2*CB-1:CB];
    assign sy       = rd_reg[CB-1:0];
    assign hit      = (sx == qx_reg) && (sy == qy_reg);
    assign ddx      = $signed({qx_reg[CB-1], qx_reg}) - $signed({sx[CB-1], sx});
    assign ddy      = $signed({qy_reg[CB-1], qy_reg}) - $signed({sy[CB-1], sy});
    assign t        = {rem_reg[RW:0], rad_reg[SW-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign ge       = (t >= trial);
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        st_next      = st_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        rem_cnt_next = rem_cnt_reg;
        found_next   = found_reg;
        have_next    = have_reg;
        best_d_next  = best_d_reg;
        best_x_next  = best_x_reg;
        best_y_next  = best_y_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_re       = 1'b0;
        mem_ra       = idx_reg[AW-1:0];

        out_valid_next = (out_valid_reg && !rsp.ready);
        o_st_next      = o_st_reg;
        o_found_next   = o_found_reg;
        o_x_next       = o_x_reg;
        o_y_next       = o_y_reg;
        o_d_next       = o_d_reg;
        o_rm_next      = o_rm_reg;
        o_cnt_next     = o_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop          = 1'b1;
                    op_next      = head.func;
                    qx_next      = head_x;
                    qy_next      = head_y;
                    idx_next     = '0;
                    wr_next      = '0;
                    rem_cnt_next = '0;
                    found_next   = 1'b0;
                    have_next    = 1'b0;
                    st_next      = ST_OK;
                    state_next   = S_SCAN;
                    unique case (head.func)
                        FN_ADD:
                        begin
                            state_next = S_DONE;
                            if (count_reg == CW'(CAPACITY))
                                st_next = ST_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = count_reg[AW-1:0];
                                mem_wd     = {head_x, head_y};
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        FN_NEAREST:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                        end
                        FN_REMOVE, FN_MEMBER:
                            state_next = S_SCAN;
                        default:
                            state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    if (op_reg == FN_REMOVE)
                        count_next = wr_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SCAN;
                idx_next   = CW'(idx_reg + 1'b1);
                priority case (op_reg)
                    FN_REMOVE:
                    begin
                        if (hit)
                            rem_cnt_next = CW'(rem_cnt_reg + 1'b1);
                        else
                        begin
                            mem_we  = 1'b1;
                            mem_wa  = wr_reg[AW-1:0];
                            mem_wd  = rd_reg;
                            wr_next = CW'(wr_reg + 1'b1);
                        end
                    end
                    FN_MEMBER:
                    begin
                        if (hit)
                            found_next = 1'b1;
                    end
                    default:
                    begin
                        idx_next   = idx_reg;
                        dx_next    = ddx[RW] ? RW'(-ddx) : ddx[RW-1:0];
                        dy_next    = ddy[RW] ? RW'(-ddy) : ddy[RW-1:0];
                        state_next = S_MUL;
                    end
                endcase
            end
            S_MUL:
            begin
                sqx_next   = dx_reg * dx_reg;
                sqy_next   = dy_reg * dy_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                rad_next   = sqx_reg + sqy_reg;
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rem_next  = ge ? (RW+2)'(t - trial) : t[RW+1:0];
                root_next = {root_reg[RW-2:0], ge};
                rad_next  = {rad_reg[SW-3:0], 2'b00};
                step_next = SCW'(step_reg + 1'b1);
                if (step_reg == SCW'(RW - 1))
                    state_next = S_BEST;
            end
            S_BEST:
            begin
                if (!have_reg || (root_reg < best_d_reg))
                begin
                    have_next   = 1'b1;
                    best_d_next = root_reg;
                    best_x_next = sx;
                    best_y_next = sy;
                end
                idx_next   = CW'(idx_reg + 1'b1);
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_st_next      = st_reg;
                    o_found_next   = ((op_reg == FN_MEMBER) && found_reg)
                                   || ((op_reg == FN_NEAREST) && have_reg);
                    o_x_next       = '0;
                    o_y_next       = '0;
                    o_d_next       = '0;
                    if ((op_reg == FN_NEAREST) && have_reg)
                    begin
                        o_x_next = best_x_reg;
                        o_y_next = best_y_reg;
                        o_d_next = (32'(best_d_reg) > 32'h1FFFF) ?
                                   DIST_W'(17'h1FFFF) : DIST_W'(best_d_reg);
                    end
                    o_rm_next  = (op_reg == FN_REMOVE) ?
                                 sat_cnt(32'(rem_cnt_reg)) : '0;
                    o_cnt_next = sat_cnt(32'(count_reg));
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            wr_reg        <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        st_reg      <= st_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        rem_cnt_reg <= rem_cnt_next;
        found_reg   <= found_next;
        have_reg    <= have_next;
        best_d_reg  <= best_d_next;
        best_x_reg  <= best_x_next;
        best_y_reg  <= best_y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        o_st_reg    <= o_st_next;
        o_found_reg <= o_found_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_d_reg     <= o_d_next;
        o_rm_reg    <= o_rm_next;
        o_cnt_reg   <= o_cnt_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_st_reg;
    assign rsp.found         = o_found_reg;
    assign rsp.near_x        = o_x_reg;
    assign rsp.near_y        = o_y_reg;
    assign rsp.near_dist     = o_d_reg;
    assign rsp.removed_count = o_rm_reg;
    assign rsp.entry_count   = o_cnt_reg;

    `PTNS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY))
    `PTNS_ASSERT(a_compact_order, clk, rst_n,
        (state_reg == S_SCAN) |-> ((wr_reg <= idx_reg) && (idx_reg <= count_reg)))
    `PTNS_ASSERT_NEVER(a_pop_busy, clk, rst_n, pop && (state_reg != S_IDLE))
endmodule
